// ===== hdl/animated_sprite_slot_pool_core_assert.svh =====
// Assertion macros for the sprite slot pool.
`ifndef ANIMATED_SPRITE_SLOT_POOL_CORE_ASSERT_SVH
`define ANIMATED_SPRITE_SLOT_POOL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ASP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASP_ASSERT(name, clk, rstn, prop, msg)
`define ASP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== hdl/asp_pkg.sv =====
package asp_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  localparam int REQ_W   = 2;
  localparam int RESP_W  = 2;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 16;
  localparam int IDX_W   = 4;
  localparam int TICK_W  = 6;
  localparam int FRAME_W = 4;
  localparam int SCALE_W = 9;
  localparam int RECIP_W = 10;
  localparam int PROD_W  = TICK_W + RECIP_W;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [RESP_W-1:0] RESP_ADD   = 2'd0;
  localparam logic [RESP_W-1:0] RESP_DRAW  = 2'd1;
  localparam logic [RESP_W-1:0] RESP_NONE  = 2'd2;
  localparam logic [RESP_W-1:0] RESP_CLEAR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_go;
    logic tick_go;
    logic clear;
    logic add_step;
    logic tick_step;
    logic tick_finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_slot;
    logic free_hit;
  } sts_t;

  function automatic logic [FRAME_W-1:0] kind_frames(input logic [KIND_W-1:0] k);
    logic [FRAME_W-1:0] f;
    unique case (k)
      2'd0: f = 4'd8;
      2'd1: f = 4'd9;
      2'd2: f = 4'd10;
      2'd3: f = 4'd8;
      default: f = 4'd8;
    endcase
    return f;
  endfunction

  function automatic logic [SCALE_W-1:0] kind_scale(input logic [KIND_W-1:0] k);
    logic [SCALE_W-1:0] s;
    unique case (k)
      2'd0: s = 9'd77;
      2'd1: s = 9'd256;
      2'd2: s = 9'd256;
      2'd3: s = 9'd192;
      default: s = 9'd256;
    endcase
    return s;
  endfunction

  // Reciprocal of ticks per frame in units of 1/1024; exact for 6-bit counts.
  function automatic logic [RECIP_W-1:0] kind_recip(input logic [KIND_W-1:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      2'd0: r = 10'd171;
      2'd1: r = 10'd205;
      2'd2: r = 10'd512;
      2'd3: r = 10'd342;
      default: r = 10'd512;
    endcase
    return r;
  endfunction

  // Tick count divided by ticks per frame, full width.
  function automatic logic [TICK_W-1:0] frame_of(input logic [KIND_W-1:0] k,
                                                 input logic [TICK_W-1:0] t);
    logic [PROD_W-1:0] p;
    p = PROD_W'(t) * PROD_W'(kind_recip(k));
    return p[PROD_W-1:RECIP_W];
  endfunction

endpackage

// ===== hdl/asp_ctrl.sv =====
module asp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [asp_pkg::REQ_W-1:0] req_type_i,
  input  asp_pkg::sts_t             sts_i,
  output asp_pkg::cmd_t             cmd_o,
  output logic                      busy
);
  import asp_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_ADD      = 2'd1;
  localparam logic [1:0] S_TICK     = 2'd2;
  localparam logic [1:0] S_TICK_END = 2'd3;

  logic [1:0] st_q, st_d;

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_type_i)
            REQ_ADD: begin
              cmd_o.add_go = 1'b1;
              st_d         = S_ADD;
            end
            REQ_TICK: begin
              cmd_o.tick_go = 1'b1;
              st_d          = S_TICK;
            end
            REQ_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_ADD: begin
        cmd_o.add_step = 1'b1;
        if (sts_i.free_hit || sts_i.last_slot) st_d = S_IDLE;
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.last_slot) st_d = S_TICK_END;
      end
      S_TICK_END: begin
        cmd_o.tick_finish = 1'b1;
        st_d              = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  assign busy = (st_q != S_IDLE);

endmodule

// ===== hdl/asp_datapath.sv =====
`include "animated_sprite_slot_pool_core_assert.svh"

module asp_datapath #(
  parameter int SLOT_COUNT = asp_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  asp_pkg::cmd_t               cmd_i,
  output asp_pkg::sts_t               sts_o,
  input  logic [asp_pkg::KIND_W-1:0]  effect_kind_i,
  input  logic signed [asp_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [asp_pkg::POS_W-1:0] pos_y_i,
  output logic                        strobe_o,
  output logic [asp_pkg::RESP_W-1:0]  resp_kind_o,
  output logic [asp_pkg::IDX_W-1:0]   slot_index_o,
  output logic                        pool_full_o,
  output logic signed [asp_pkg::POS_W-1:0] draw_x_o,
  output logic signed [asp_pkg::POS_W-1:0] draw_y_o,
  output logic [asp_pkg::KIND_W-1:0]  draw_kind_o,
  output logic [asp_pkg::FRAME_W-1:0] frame_number_o,
  output logic [asp_pkg::SCALE_W-1:0] scale_q8_o,
  output logic                        last_item_o
);
  import asp_pkg::*;

  localparam int PW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ATTR_W = KIND_W + 2 * POS_W;

  // Slot storage: busy bits in flops, the rest in memories read one slot ahead.
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [TICK_W-1:0]     tick_mem [SLOT_COUNT];
  logic [ATTR_W-1:0]     attr_mem [SLOT_COUNT];
  logic [TICK_W-1:0]     tick_rd_q;
  logic [ATTR_W-1:0]     attr_rd_q;

  logic [PW-1:0]     ptr_q, ptr_d, rd_addr;
  logic              last_slot, cur_busy;

  logic [KIND_W-1:0] req_kind_q;
  logic [POS_W-1:0]  req_x_q, req_y_q;

  logic [KIND_W-1:0] rd_kind;
  logic [POS_W-1:0]  rd_x, rd_y;
  logic [TICK_W-1:0] tick_new, frame_full;
  logic              slot_done, listed, add_hit, wr_add, wr_tick;

  // Draw item held back until it is known whether it is the final one.
  logic              pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]  pend_idx_q;
  logic [POS_W-1:0]  pend_x_q, pend_y_q;
  logic [KIND_W-1:0] pend_kind_q;
  logic [FRAME_W-1:0] pend_frame_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic               strobe_q, strobe_d;
  logic [RESP_W-1:0]  resp_q, resp_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               full_q, full_d;
  logic [POS_W-1:0]   x_q, x_d, y_q, y_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic               last_q, last_d;

  assign last_slot = (ptr_q == PW'(SLOT_COUNT - 1));
  assign cur_busy  = busy_q[ptr_q];
  assign {rd_kind, rd_x, rd_y} = attr_rd_q;

  assign add_hit    = cmd_i.add_step && !cur_busy;
  assign wr_add     = add_hit;
  assign tick_new   = tick_rd_q + TICK_W'(1);
  assign frame_full = frame_of(rd_kind, tick_new);
  assign slot_done  = (frame_full >= TICK_W'(kind_frames(rd_kind)));
  assign wr_tick    = cmd_i.tick_step && cur_busy;
  assign listed     = wr_tick && !slot_done && (cnt_q < CNT_W'(MAX_RESULTS));

  assign sts_o.last_slot = last_slot;
  assign sts_o.free_hit  = add_hit;

  always_comb begin
    if (cmd_i.add_go || cmd_i.tick_go || last_slot) begin
      rd_addr = '0;
    end else begin
      rd_addr = ptr_q + PW'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.add_go || cmd_i.tick_go) begin
      ptr_d = '0;
    end else if (cmd_i.add_step || cmd_i.tick_step) begin
      ptr_d = ptr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_add) begin
      tick_mem[ptr_q] <= '0;
      attr_mem[ptr_q] <= {req_kind_q, req_x_q, req_y_q};
    end else if (wr_tick) begin
      tick_mem[ptr_q] <= tick_new;
    end
    tick_rd_q <= tick_mem[rd_addr];
    attr_rd_q <= attr_mem[rd_addr];
  end

  always_comb begin
    busy_d = busy_q;
    if (cmd_i.clear) begin
      busy_d = '0;
    end else if (wr_add) begin
      busy_d[ptr_q] = 1'b1;
    end else if (wr_tick && slot_done) begin
      busy_d[ptr_q] = 1'b0;
    end
  end

  always_comb begin
    pend_vld_d = pend_vld_q;
    cnt_d      = cnt_q;
    if (cmd_i.tick_go) begin
      pend_vld_d = 1'b0;
      cnt_d      = '0;
    end else if (listed) begin
      pend_vld_d = 1'b1;
      cnt_d      = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    strobe_d = 1'b0;
    resp_d   = RESP_ADD;
    idx_d    = '0;
    full_d   = 1'b0;
    x_d      = '0;
    y_d      = '0;
    kind_d   = '0;
    frame_d  = '0;
    scale_d  = '0;
    last_d   = 1'b1;
    priority if (cmd_i.clear) begin
      strobe_d = 1'b1;
      resp_d   = RESP_CLEAR;
    end else if (add_hit) begin
      strobe_d = 1'b1;
      idx_d    = IDX_W'(ptr_q);
    end else if (cmd_i.add_step && last_slot) begin
      strobe_d = 1'b1;
      full_d   = 1'b1;
    end else if ((listed || cmd_i.tick_finish) && pend_vld_q) begin
      // a later draw item exists unless the pass is over
      strobe_d = 1'b1;
      resp_d   = RESP_DRAW;
      idx_d    = pend_idx_q;
      x_d      = pend_x_q;
      y_d      = pend_y_q;
      kind_d   = pend_kind_q;
      frame_d  = pend_frame_q;
      scale_d  = kind_scale(pend_kind_q);
      last_d   = cmd_i.tick_finish;
    end else if (cmd_i.tick_finish) begin
      strobe_d = 1'b1;
      resp_d   = RESP_NONE;
    end else begin
      strobe_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      ptr_q      <= '0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      strobe_q   <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      ptr_q      <= ptr_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_go) begin
      req_kind_q <= effect_kind_i;
      req_x_q    <= pos_x_i;
      req_y_q    <= pos_y_i;
    end
    if (listed) begin
      pend_idx_q   <= IDX_W'(ptr_q);
      pend_x_q     <= rd_x;
      pend_y_q     <= rd_y;
      pend_kind_q  <= rd_kind;
      pend_frame_q <= frame_full[FRAME_W-1:0];
    end
    resp_q  <= resp_d;
    idx_q   <= idx_d;
    full_q  <= full_d;
    x_q     <= x_d;
    y_q     <= y_d;
    kind_q  <= kind_d;
    frame_q <= frame_d;
    scale_q <= scale_d;
    last_q  <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign resp_kind_o    = resp_q;
  assign slot_index_o   = idx_q;
  assign pool_full_o    = full_q;
  assign draw_x_o       = x_q;
  assign draw_y_o       = y_q;
  assign draw_kind_o    = kind_q;
  assign frame_number_o = frame_q;
  assign scale_q8_o     = scale_q;
  assign last_item_o    = last_q;

  `ASP_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_RESULTS), "draw count overran")
  `ASP_ASSERT(a_full_on_add, clk_i, rst_ni, full_q |-> resp_q == RESP_ADD, "full flag off an add")
  `ASP_ASSERT(a_finish_last, clk_i, rst_ni, cmd_i.tick_finish |=> strobe_q && last_q, "no final item")
  `ASP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !strobe_q, "strobe after reset")

endmodule

// ===== hdl/animated_sprite_slot_pool_core.sv =====
// Add: slots are searched from slot 0 and the first free one is taken and reported;
//   a full pool answers at the last slot; the next start is taken as the result shows.
// Tick: one slot per cycle through the slot memory read port; a draw item is held
//   until the next is listed or the pass ends; the last comes with the next start.
// Clear: result on the next cycle, a new start taken every cycle.
// Results cannot be stalled. Reset frees all slots and idles the controller.
module animated_sprite_slot_pool_core #(
  parameter int SLOT_COUNT = asp_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [asp_pkg::REQ_W-1:0]        req_type_i,
  input  logic [asp_pkg::KIND_W-1:0]       effect_kind_i,
  input  logic signed [asp_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [asp_pkg::POS_W-1:0] pos_y_i,
  output logic                             strobe_o,
  output logic [asp_pkg::RESP_W-1:0]       resp_kind_o,
  output logic [asp_pkg::IDX_W-1:0]        slot_index_o,
  output logic                             pool_full_o,
  output logic signed [asp_pkg::POS_W-1:0] draw_x_o,
  output logic signed [asp_pkg::POS_W-1:0] draw_y_o,
  output logic [asp_pkg::KIND_W-1:0]       draw_kind_o,
  output logic [asp_pkg::FRAME_W-1:0]      frame_number_o,
  output logic [asp_pkg::SCALE_W-1:0]      scale_q8_o,
  output logic                             last_item_o
);
  import asp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  asp_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .effect_kind_i  (effect_kind_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .strobe_o       (strobe_o),
    .resp_kind_o    (resp_kind_o),
    .slot_index_o   (slot_index_o),
    .pool_full_o    (pool_full_o),
    .draw_x_o       (draw_x_o),
    .draw_y_o       (draw_y_o),
    .draw_kind_o    (draw_kind_o),
    .frame_number_o (frame_number_o),
    .scale_q8_o     (scale_q8_o),
    .last_item_o    (last_item_o)
  );

endmodule

// ===== test/tb_animated_sprite_slot_pool_core.sv =====
`timescale 1ns / 1ps

module tb_animated_sprite_slot_pool_core;
  import asp_pkg::*;

  localparam int POOL_SLOTS = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_LIMIT = 10;
  // Request code that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  typedef struct packed {
    logic [RESP_W-1:0]       resp;
    logic [IDX_W-1:0]        idx;
    logic                    full;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [KIND_W-1:0]       kind;
    logic [FRAME_W-1:0]      frame;
    logic [SCALE_W-1:0]      scale;
    logic                    last;
  } sprite_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    typed;
    logic [RESP_W-1:0]       typed_resp;
    logic [IDX_W-1:0]        typed_idx;
    logic                    typed_full;
  } sprite_req_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [REQ_W-1:0]        req_type_i = '0;
  logic [KIND_W-1:0]       effect_kind_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0;
  logic signed [POS_W-1:0] pos_y_i = '0;
  logic                    strobe_o;
  logic [RESP_W-1:0]       resp_kind_o;
  logic [IDX_W-1:0]        slot_index_o;
  logic                    pool_full_o;
  logic signed [POS_W-1:0] draw_x_o;
  logic signed [POS_W-1:0] draw_y_o;
  logic [KIND_W-1:0]       draw_kind_o;
  logic [FRAME_W-1:0]      frame_number_o;
  logic [SCALE_W-1:0]      scale_q8_o;
  logic                    last_item_o;

  // Predicted pool contents.
  logic                    pool_busy [POOL_SLOTS];
  logic [TICK_W-1:0]       pool_ticks [POOL_SLOTS];
  logic [KIND_W-1:0]       pool_kind [POOL_SLOTS];
  logic signed [POS_W-1:0] pool_x [POOL_SLOTS];
  logic signed [POS_W-1:0] pool_y [POOL_SLOTS];

  sprite_result_t draws_due [$];
  sprite_req_t    directed_rows [$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  bit             no_idle_stretch = 1'b0;

  animated_sprite_slot_pool_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .effect_kind_i  (effect_kind_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .strobe_o       (strobe_o),
    .resp_kind_o    (resp_kind_o),
    .slot_index_o   (slot_index_o),
    .pool_full_o    (pool_full_o),
    .draw_x_o       (draw_x_o),
    .draw_y_o       (draw_y_o),
    .draw_kind_o    (draw_kind_o),
    .frame_number_o (frame_number_o),
    .scale_q8_o     (scale_q8_o),
    .last_item_o    (last_item_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int unsigned ticks_per_frame(input logic [KIND_W-1:0] k);
    case (k)
      2'd0: return 6;
      2'd1: return 5;
      2'd2: return 2;
      default: return 3;
    endcase
  endfunction

  function automatic int unsigned frames_of_kind(input logic [KIND_W-1:0] k);
    case (k)
      2'd0: return 8;
      2'd1: return 9;
      2'd2: return 10;
      default: return 8;
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] scale_of_kind(input logic [KIND_W-1:0] k);
    case (k)
      2'd0: return 9'd77;
      2'd3: return 9'd192;
      default: return 9'd256;
    endcase
  endfunction

  function automatic sprite_result_t short_result(input logic [RESP_W-1:0] resp,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic full);
    sprite_result_t r;
    r = '0;
    r.resp = resp;
    r.idx = idx;
    r.full = full;
    r.last = 1'b1;
    return r;
  endfunction

  // Apply one transaction to the predicted pool and queue its results.
  task automatic model_sprite_request(input sprite_req_t rq);
    sprite_result_t outs [$];
    sprite_result_t r;
    int             slot;
    bit             placed;
    logic [TICK_W-1:0] t;
    placed = 1'b0;
    case (rq.req)
      REQ_ADD: begin
        for (slot = 0; slot < POOL_SLOTS && !placed; slot++) begin
          if (!pool_busy[slot]) begin
            pool_busy[slot] = 1'b1;
            pool_ticks[slot] = '0;
            pool_kind[slot] = rq.kind;
            pool_x[slot] = rq.x;
            pool_y[slot] = rq.y;
            outs.push_back(short_result(RESP_ADD, IDX_W'(slot), 1'b0));
            placed = 1'b1;
          end
        end
        if (!placed) outs.push_back(short_result(RESP_ADD, '0, 1'b1));
      end
      REQ_TICK: begin
        for (slot = 0; slot < POOL_SLOTS; slot++) begin
          if (pool_busy[slot]) begin
            t = pool_ticks[slot] + 1'b1;
            pool_ticks[slot] = t;
            if (t / ticks_per_frame(pool_kind[slot]) >= frames_of_kind(pool_kind[slot]))
              pool_busy[slot] = 1'b0;
          end
        end
        for (slot = 0; slot < POOL_SLOTS && outs.size() < MAX_RESULTS; slot++) begin
          if (pool_busy[slot]) begin
            r = '0;
            r.resp = RESP_DRAW;
            r.idx = IDX_W'(slot);
            r.x = pool_x[slot];
            r.y = pool_y[slot];
            r.kind = pool_kind[slot];
            r.frame = FRAME_W'(pool_ticks[slot] / ticks_per_frame(pool_kind[slot]));
            r.scale = scale_of_kind(pool_kind[slot]);
            outs.push_back(r);
          end
        end
        if (outs.size() == 0) outs.push_back(short_result(RESP_NONE, '0, 1'b0));
        else outs[outs.size()-1].last = 1'b1;
      end
      REQ_CLEAR: begin
        for (slot = 0; slot < POOL_SLOTS; slot++) pool_busy[slot] = 1'b0;
        outs.push_back(short_result(RESP_CLEAR, '0, 1'b0));
      end
      default: ;
    endcase
    if (rq.typed) draws_due.push_back(short_result(rq.typed_resp, rq.typed_idx, rq.typed_full));
    else foreach (outs[i]) draws_due.push_back(outs[i]);
  endtask

  function automatic sprite_req_t make_row(input logic [REQ_W-1:0] req,
                                           input logic [KIND_W-1:0] kind,
                                           input logic signed [POS_W-1:0] x,
                                           input logic signed [POS_W-1:0] y,
                                           input logic typed,
                                           input logic [RESP_W-1:0] resp,
                                           input logic [IDX_W-1:0] idx,
                                           input logic full);
    sprite_req_t rq;
    rq.req = req;
    rq.kind = kind;
    rq.x = x;
    rq.y = y;
    rq.typed = typed;
    rq.typed_resp = resp;
    rq.typed_idx = idx;
    rq.typed_full = full;
    return rq;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    return POS_W'($urandom);
  endfunction

  function automatic sprite_req_t random_row(input logic [REQ_W-1:0] req);
    return make_row(req, KIND_W'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                    1'b0, RESP_ADD, '0, 1'b0);
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (no_idle_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start until the block takes the transaction.
  task automatic issue_request(input sprite_req_t rq);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= rq.req;
    effect_kind_i <= rq.kind;
    pos_x_i <= rq.x;
    pos_y_i <= rq.y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model_sprite_request(rq);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (draws_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input sprite_result_t want,
                                 input sprite_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t %s", $realtime, what);
      $display("  expected resp=%0d idx=%0d full=%0d x=%0d y=%0d kind=%0d frame=%0d scale=%0d last=%0d",
               want.resp, want.idx, want.full, want.x, want.y, want.kind, want.frame,
               want.scale, want.last);
      $display("  actual   resp=%0d idx=%0d full=%0d x=%0d y=%0d kind=%0d frame=%0d scale=%0d last=%0d",
               got.resp, got.idx, got.full, got.x, got.y, got.kind, got.frame,
               got.scale, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    sprite_result_t got;
    sprite_result_t want;
    if (rst_ni && strobe_o) begin
      got.resp = resp_kind_o;
      got.idx = slot_index_o;
      got.full = pool_full_o;
      got.x = draw_x_o;
      got.y = draw_y_o;
      got.kind = draw_kind_o;
      got.frame = frame_number_o;
      got.scale = scale_q8_o;
      got.last = last_item_o;
      if (draws_due.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
      end else begin
        want = draws_due.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned issued;
    int unsigned episode;
    int unsigned n;
    bit          paused;
    for (int s = 0; s < POOL_SLOTS; s++) begin
      pool_busy[s] = 1'b0;
      pool_ticks[s] = '0;
      pool_kind[s] = '0;
      pool_x[s] = '0;
      pool_y[s] = '0;
    end

    // Empty pool, fill it with all kinds (first at the coordinate extremes) until an add finds it full, then clear.
    directed_rows.push_back(make_row(REQ_TICK, 2'd0, 16'sh0, 16'sh0, 1'b1, RESP_NONE, '0, 1'b0));
    directed_rows.push_back(make_row(REQ_CLEAR, 2'd0, 16'sh0, 16'sh0, 1'b1, RESP_CLEAR, '0,
                                     1'b0));
    directed_rows.push_back(make_row(REQ_ADD, 2'd0, 16'sh8000, 16'sh7fff, 1'b1, RESP_ADD, 4'd0,
                                     1'b0));
    directed_rows.push_back(make_row(REQ_ADD, 2'd1, 16'sh7fff, 16'sh8000, 1'b1, RESP_ADD, 4'd1,
                                     1'b0));
    directed_rows.push_back(make_row(REQ_ADD, 2'd2, 16'sh0, 16'sh0, 1'b1, RESP_ADD, 4'd2, 1'b0));
    directed_rows.push_back(make_row(REQ_ADD, 2'd3, -16'sd1, 16'sd1, 1'b1, RESP_ADD, 4'd3,
                                     1'b0));
    directed_rows.push_back(make_row(REQ_TICK, 2'd0, 16'sh0, 16'sh0, 1'b0, RESP_ADD, '0, 1'b0));
    directed_rows.push_back(make_row(REQ_IGNORED, 2'd3, -16'sd1, -16'sd1, 1'b0, RESP_ADD, '0,
                                     1'b0));
    for (int s = 4; s < POOL_SLOTS; s++)
      directed_rows.push_back(make_row(REQ_ADD, KIND_W'(s), POS_W'(s * 1000), -POS_W'(s * 77),
                                       1'b1, RESP_ADD, IDX_W'(s), 1'b0));
    directed_rows.push_back(make_row(REQ_ADD, 2'd1, 16'sh1234, 16'sh4321, 1'b1, RESP_ADD, '0,
                                     1'b1));
    directed_rows.push_back(make_row(REQ_TICK, 2'd0, 16'sh0, 16'sh0, 1'b0, RESP_ADD, '0, 1'b0));
    directed_rows.push_back(make_row(REQ_CLEAR, 2'd2, 16'sh5555, 16'shaaaa, 1'b1, RESP_CLEAR, '0,
                                     1'b0));
    directed_rows.push_back(make_row(REQ_TICK, 2'd0, 16'sh0, 16'sh0, 1'b1, RESP_NONE, '0, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) issue_request(directed_rows[i]);
    drain_results();

    issued = 0;
    paused = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      no_idle_stretch = ($urandom_range(0, 4) == 0);
      episode = $urandom_range(0, 9);
      if (episode < 4) begin
        // Fill: often runs into a full pool.
        n = $urandom_range(4, 20);
        repeat (n) issue_request(random_row(REQ_ADD));
        issued += n;
        repeat ($urandom_range(1, 3)) begin
          issue_request(random_row(REQ_TICK));
          issued++;
        end
      end else if (episode < 8) begin
        // Animate until sprites run out of frames, with an occasional add.
        n = $urandom_range(5, 30);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            issue_request(random_row(REQ_ADD));
            issued++;
          end
          issue_request(random_row(REQ_TICK));
        end
        issued += n;
      end else if (episode == 8) begin
        issue_request(random_row(REQ_CLEAR));
        issued++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          issue_request(random_row(REQ_W'($urandom_range(0, 3))));
          issued++;
        end
      end
      if (!paused && issued >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (POOL_SLOTS + 8) @(posedge clk_i);
    if (mismatch_count == 0 && draws_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
